@@ sv/hbs_pkg.sv @@
package hbs_pkg;

    // Grid size and derived index widths
    localparam int MAP_W  = 256;
    localparam int MAP_H  = 256;
    localparam int COL_W  = (MAP_W > 1) ? $clog2(MAP_W) : 1;
    localparam int ROW_W  = (MAP_H > 1) ? $clog2(MAP_H) : 1;
    localparam int DEPTH  = MAP_W * MAP_H;
    localparam int ADDR_W = $clog2(DEPTH);

    // Field widths
    localparam int HGT_W  = 16;   // Q8.8 height
    localparam int XY_W   = 18;   // Q10.8 coordinate
    localparam int IDX_W  = 8;    // cell_col / cell_row
    localparam int FRAC_W = 8;    // fraction bits of coordinates

    // Bounds compare width: wide enough for MAP_W * 256 and MAP_H * 256
    localparam int LIM_W  = 20;
    localparam int X_LIM  = MAP_W << FRAC_W;
    localparam int Y_LIM  = MAP_H << FRAC_W;
    localparam int CMP_W  = 11;

    // MAC datapath widths
    localparam int WGT_W  = FRAC_W + 1;           // weight 0..256
    localparam int OPD_W  = HGT_W + FRAC_W + 1;   // row blend result
    localparam int ACC_W  = OPD_W + FRAC_W + 1;   // final blend result
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1 << FRAC_W);
    localparam int RND_BIAS = (1 << (2 * FRAC_W)) - 1;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Control word for the shared multiply-accumulate unit
    typedef struct packed {
        logic                    en;
        logic                    clear;
        logic [WGT_W-1:0]        weight;
        logic signed [OPD_W-1:0] operand;
    } t_mac_ctl;

endpackage

@@ sv/heightmap_bilinear_sampler_core.sv @@
// Write item: RAM written at the accept edge; S_DONE is busy, then the result strobe.
// Out-of-map query: same timing as a write.
// In-map query: four cell reads from the single-port height RAM and six passes through
// one shared multiply-accumulate unit, the first four of them as the cells arrive.
// The next item may start in the strobe cycle; results are never stalled.
// Synchronous active-low reset clears control; the height RAM is not cleared.
module heightmap_bilinear_sampler_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  i_opcode,
    input  logic signed [hbs_pkg::XY_W-1:0]       i_query_x,
    input  logic signed [hbs_pkg::XY_W-1:0]       i_query_y,
    input  logic [hbs_pkg::IDX_W-1:0]             i_cell_col,
    input  logic [hbs_pkg::IDX_W-1:0]             i_cell_row,
    input  logic signed [hbs_pkg::HGT_W-1:0]      i_cell_height,
    output logic                                  busy,
    output logic                                  o_valid,
    output logic signed [hbs_pkg::HGT_W-1:0]      o_height,
    output logic                                  o_out_of_map,
    output logic                                  o_write_done
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_BLEND = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic r_valid, n_valid;

    logic signed [hbs_pkg::XY_W-1:0]  r_x, r_y;
    logic                             r_is_wr, r_oom;
    logic signed [hbs_pkg::OPD_W-1:0] r_h1, r_h2;
    logic signed [hbs_pkg::HGT_W-1:0] r_height;
    logic                             r_out_of_map, r_write_done;

    logic                              w_accept, w_in_map, w_we;
    logic [hbs_pkg::ADDR_W-1:0]        w_waddr, w_raddr, w_addr;
    logic signed [hbs_pkg::HGT_W-1:0]  w_rdata;
    logic [hbs_pkg::COL_W-1:0]         w_cx, w_cx1, w_col;
    logic [hbs_pkg::ROW_W-1:0]         w_cy, w_cy1, w_row;
    logic [hbs_pkg::FRAC_W-1:0]        w_fx, w_fy;
    logic [1:0]                        w_k;
    logic signed [hbs_pkg::ACC_W-1:0]  w_acc, w_biased;
    hbs_pkg::t_mac_ctl                 w_mac;

    assign w_accept = start && !busy;

    // Query point inside the grid
    assign w_in_map = !i_query_x[hbs_pkg::XY_W-1] && !i_query_y[hbs_pkg::XY_W-1]
        && (hbs_pkg::LIM_W'(i_query_x[hbs_pkg::XY_W-2:0]) < hbs_pkg::LIM_W'(hbs_pkg::X_LIM))
        && (hbs_pkg::LIM_W'(i_query_y[hbs_pkg::XY_W-2:0]) < hbs_pkg::LIM_W'(hbs_pkg::Y_LIM));

    // Write goes straight to the RAM at the accept edge; off-grid writes are dropped
    assign w_we = w_accept && (i_opcode == hbs_pkg::OP_WRITE)
        && (hbs_pkg::CMP_W'(i_cell_col) < hbs_pkg::CMP_W'(hbs_pkg::MAP_W))
        && (hbs_pkg::CMP_W'(i_cell_row) < hbs_pkg::CMP_W'(hbs_pkg::MAP_H));
    assign w_waddr = hbs_pkg::ADDR_W'(i_cell_row) * hbs_pkg::ADDR_W'(hbs_pkg::MAP_W)
                   + hbs_pkg::ADDR_W'(i_cell_col);

    // Cell coordinates and fractions of the held query point
    assign w_cx  = r_x[hbs_pkg::FRAC_W +: hbs_pkg::COL_W];
    assign w_cy  = r_y[hbs_pkg::FRAC_W +: hbs_pkg::ROW_W];
    assign w_fx  = r_x[hbs_pkg::FRAC_W-1:0];
    assign w_fy  = r_y[hbs_pkg::FRAC_W-1:0];
    assign w_cx1 = (w_cx == hbs_pkg::COL_W'(hbs_pkg::MAP_W - 1)) ? w_cx : w_cx + 1'b1;
    assign w_cy1 = (w_cy == hbs_pkg::ROW_W'(hbs_pkg::MAP_H - 1)) ? w_cy : w_cy + 1'b1;

    // Neighbor order: (cx,cy), (cx1,cy), (cx,cy1), (cx1,cy1)
    assign w_col   = r_cnt[0] ? w_cx1 : w_cx;
    assign w_row   = r_cnt[1] ? w_cy1 : w_cy;
    assign w_raddr = hbs_pkg::ADDR_W'(w_row) * hbs_pkg::ADDR_W'(hbs_pkg::MAP_W)
                   + hbs_pkg::ADDR_W'(w_col);
    assign w_addr  = w_we ? w_waddr : w_raddr;

    // Index of the cell whose data is on the RAM output
    assign w_k = 2'(r_cnt - 3'd1);

    hbs_ram #(
        .WIDTH (hbs_pkg::HGT_W),
        .DEPTH (hbs_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (i_cell_height),
        .o_rdata (w_rdata)
    );

    hbs_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac),
        .o_acc (w_acc)
    );

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_valid       = 1'b0;
        w_mac.en      = 1'b0;
        w_mac.clear   = 1'b0;
        w_mac.weight  = '0;
        w_mac.operand = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cnt = '0;
                    if (i_opcode == hbs_pkg::OP_QUERY && w_in_map) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: begin
                // Blend each row along x as its cells arrive
                w_mac.en      = (r_cnt != 3'd0);
                w_mac.clear   = !w_k[0];
                w_mac.weight  = w_k[0] ? hbs_pkg::WGT_W'(w_fx)
                                       : hbs_pkg::WGT_ONE - hbs_pkg::WGT_W'(w_fx);
                w_mac.operand = hbs_pkg::OPD_W'(w_rdata);
                if (r_cnt == 3'd4) begin
                    n_state = S_BLEND;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_BLEND: begin
                // Blend the two rows along y
                w_mac.en      = 1'b1;
                w_mac.clear   = !r_cnt[0];
                w_mac.weight  = r_cnt[0] ? hbs_pkg::WGT_W'(w_fy)
                                         : hbs_pkg::WGT_ONE - hbs_pkg::WGT_W'(w_fy);
                w_mac.operand = r_cnt[0] ? r_h2 : r_h1;
                if (r_cnt[0]) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Truncate toward zero on the divide by 2^16
    assign w_biased = w_acc + (w_acc[hbs_pkg::ACC_W-1] ? hbs_pkg::ACC_W'(hbs_pkg::RND_BIAS)
                                                        : hbs_pkg::ACC_W'(0));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x     <= i_query_x;
            r_y     <= i_query_y;
            r_is_wr <= (i_opcode == hbs_pkg::OP_WRITE);
            r_oom   <= (i_opcode == hbs_pkg::OP_QUERY) && !w_in_map;
        end
        // Hold the lower row blend while the upper one accumulates
        if (r_state == S_FETCH && r_cnt == 3'd3) begin
            r_h1 <= w_acc[hbs_pkg::OPD_W-1:0];
        end
        if (r_state == S_BLEND && !r_cnt[0]) begin
            r_h2 <= w_acc[hbs_pkg::OPD_W-1:0];
        end
        if (r_state == S_DONE) begin
            r_height     <= (r_is_wr || r_oom) ? '0
                          : w_biased[2*hbs_pkg::FRAC_W +: hbs_pkg::HGT_W];
            r_out_of_map <= r_oom;
            r_write_done <= r_is_wr;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_height     = r_height;
    assign o_out_of_map = r_out_of_map;
    assign o_write_done = r_write_done;

    // A result never shows while an item is in progress
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // One strobe per item
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // Accepted write is acknowledged with a write-done result strobe
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode == hbs_pkg::OP_WRITE) |-> ##2 (o_valid && o_write_done))
        else $error("write not acknowledged");

    // Write acks and off-grid answers carry zero height and exclusive flags
    a_zero_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out_of_map || o_write_done)) |->
            (o_height == '0 && !(o_out_of_map && o_write_done)))
        else $error("flagged result with nonzero height");

    // The RAM is written only at an accept edge
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE))
        else $error("RAM write outside idle");

endmodule

@@ sv/hbs_ram.sv @@
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: optional write plus registered read of the same address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/hbs_mac.sv @@
module hbs_mac (
    input  logic                                   i_clk,
    input  hbs_pkg::t_mac_ctl                      i_ctl,
    output logic signed [hbs_pkg::ACC_W-1:0]       o_acc
);

    logic signed [hbs_pkg::ACC_W-1:0] w_prod;
    logic signed [hbs_pkg::ACC_W-1:0] r_acc;

    // Unsigned weight times signed operand
    assign w_prod = hbs_pkg::ACC_W'($signed({1'b0, i_ctl.weight}))
                  * hbs_pkg::ACC_W'(i_ctl.operand);

    // Load or accumulate the product
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= i_ctl.clear ? w_prod : r_acc + w_prod;
        end
    end

    assign o_acc = r_acc;

endmodule
